// ===== hw/rtl/fcp_pkg.sv =====
// Shared types and constants for the friction cone projection unit.
// No dependencies; compiled first.
package fcp_pkg;

	// Friction coefficient: unsigned fixed point below 4.0
	localparam int MU_W       = 18;
	// Cohesion offset: unsigned fixed point
	localparam int COH_W      = 31;
	// Configuration write port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRICTION = 1'b0,
		REG_COHESION = 1'b1
	} cfg_reg_t;

endpackage

// ===== hw/rtl/fcp_stream_if.sv =====
// Valid/ready stream interfaces for the contact vector input and the result word.
// No dependencies besides the DATA_WIDTH parameter.
interface fcp_in_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] s_tangent_one;
	logic signed [DATA_WIDTH-1:0] s_tangent_two;
	logic signed [DATA_WIDTH-1:0] s_normal;

	modport source (output valid, output s_tangent_one, output s_tangent_two,
		output s_normal, input ready);
	modport sink (input valid, input s_tangent_one, input s_tangent_two,
		input s_normal, output ready);
endinterface

interface fcp_out_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] r_tangent_one;
	logic signed [DATA_WIDTH-1:0] r_tangent_two;
	logic signed [DATA_WIDTH-1:0] r_normal;

	modport source (output valid, output r_tangent_one, output r_tangent_two,
		output r_normal, input ready);
	modport sink (input valid, input r_tangent_one, input r_tangent_two,
		input r_normal, output ready);
endinterface

// ===== hw/rtl/fcp_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband lane.
// Standalone; instantiated by friction_cone_projection_unit.
module fcp_isqrt_pipe #(
	parameter int IN_W = 64,
	parameter int SB_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   in_x,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [IN_W/2-1:0] out_root,
	output logic [SB_W-1:0]   out_sb
);
	localparam int ROOT_W = IN_W / 2;

	typedef struct packed {
		logic [ROOT_W:0]   rem;
		logic [ROOT_W-1:0] root;
		logic [IN_W-1:0]   xr;
		logic [SB_W-1:0]   sb;
	} sq_stage_t;

	// One digit step: bring down two bits, try root*4+1
	function automatic sq_stage_t sq_step(sq_stage_t a);
		sq_stage_t       res;
		logic [ROOT_W+2:0] rr;
		logic [ROOT_W+2:0] trial;
		rr    = {a.rem, a.xr[IN_W-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		res   = a;
		res.xr = a.xr << 2;
		if (rr >= trial) begin
			rr       = rr - trial;
			res.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			res.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		res.rem = rr[ROOT_W:0];
		return res;
	endfunction

	sq_stage_t st_q [ROOT_W];
	logic      v_q  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		sq_stage_t st_in;
		logic      v_in;
		if (k == 0) begin : g_first
			assign st_in = '{rem: '0, root: '0, xr: in_x, sb: in_sb};
			assign v_in  = in_valid;
		end else begin : g_next
			assign st_in = st_q[k-1];
			assign v_in  = v_q[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[k] <= sq_step(st_in);
			end
		end
	end

	assign out_valid = v_q[ROOT_W-1];
	assign out_root  = st_q[ROOT_W-1].root;
	assign out_sb    = st_q[ROOT_W-1].sb;

endmodule

// ===== hw/rtl/friction_cone_projection_unit.sv =====
// Friction cone projection unit: top level with config registers and datapath.
// Depends on fcp_pkg, fcp_stream_if and fcp_isqrt_pipe.
//
// Takes one contact vector per cycle and returns one projected, saturated
// vector per input. Pipeline depth is set by the bit-per-stage square root
// (DATA_WIDTH stages) and the bit-per-stage divider array (QG_W stages,
// 36 by default). The whole pipeline freezes only while the output word
// waits to be taken; otherwise a word may enter every cycle. Write the
// friction and cohesion registers only while the pipeline is empty.
module friction_cone_projection_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fcp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fcp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	fcp_in_if.sink                          in_vec,
	fcp_out_if.source                       out_vec
);
	import fcp_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int SN_W  = ((W > COH_W + 1) ? W : COH_W + 1) + 1;
	localparam int P1_W  = MU_W + W;
	localparam int P2_W  = MU_W + 1 + SN_W;
	localparam int NA_W  = (SN_W + F > P1_W + 1) ? SN_W + F : P1_W + 1;
	localparam int NUM_W = ((NA_W > P2_W) ? NA_W : P2_W) + 1;
	localparam int NU_W  = NUM_W - 1;
	localparam int QG_W  = NU_W - F;
	localparam int DEN_W = ((2 * MU_W - F > F + 1) ? 2 * MU_W - F : F + 1) + 1;
	localparam int PM_W  = MU_W + QG_W;
	localparam int HB_W  = (QG_W > PM_W - F) ? QG_W : PM_W - F;
	localparam int H_W   = HB_W + 2;
	localparam int M2_W  = HB_W + 2;
	localparam int UX_W  = F + 2;
	localparam int HX_W  = H_W + UX_W;
	localparam int M0_W  = HX_W - F;
	localparam int D0_W  = ((M0_W > W) ? M0_W : W) + 1;
	localparam int D2_W  = ((M2_W > W) ? M2_W : W) + 1;
	localparam int SB_W  = 3 * W + SN_W;
	localparam int LAST  = QG_W - 1;

	localparam logic [DEN_W-1:0] DEN_ONE = {{(DEN_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic [F:0] Q_ONE = {1'b1, {F{1'b0}}};
	localparam logic signed [UX_W-1:0] UX_ONE = {2'b01, {F{1'b0}}};
	localparam logic [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] OUT_MIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QG_W-1:0]  dvd;
		logic [QG_W-1:0]  quo;
	} gdiv_t;

	typedef struct packed {
		logic [W-1:0] rem;
		logic [F:0]   quo;
	} udiv_t;

	typedef struct packed {
		logic [W-1:0] t1;
		logic [W-1:0] t2;
		logic [W-1:0] n;
		logic [W-1:0] slen;
		logic         zero;
		logic         neg1;
		logic         neg2;
	} side_t;

	// Restoring divide step by the cone denominator
	function automatic gdiv_t gdiv_step(gdiv_t a, logic [DEN_W-1:0] d);
		gdiv_t          res;
		logic [DEN_W:0] rr;
		logic           qb;
		rr = {a.rem, a.dvd[QG_W-1]};
		qb = (rr >= {1'b0, d});
		if (qb) begin
			rr = rr - {1'b0, d};
		end
		res.rem = rr[DEN_W-1:0];
		res.dvd = a.dvd << 1;
		res.quo = {a.quo[QG_W-2:0], qb};
		return res;
	endfunction

	// Restoring divide step by the tangential length; first step has no shift
	function automatic udiv_t udiv_step(udiv_t a, logic [W-1:0] d, logic first);
		udiv_t      res;
		logic [W:0] rr;
		logic       qb;
		rr = first ? {1'b0, a.rem} : {a.rem, 1'b0};
		qb = (rr >= {1'b0, d});
		if (qb) begin
			rr = rr - {1'b0, d};
		end
		res.rem = rr[W-1:0];
		res.quo = {a.quo[F-1:0], qb};
		return res;
	endfunction

	function automatic logic [W-1:0] sat0(logic signed [D0_W-1:0] d);
		if (d[D0_W-1:W-1] != {(D0_W-W+1){d[D0_W-1]}}) begin
			return d[D0_W-1] ? OUT_MIN : OUT_MAX;
		end
		return d[W-1:0];
	endfunction

	function automatic logic [W-1:0] sat2(logic signed [D2_W-1:0] d);
		if (d[D2_W-1:W-1] != {(D2_W-W+1){d[D2_W-1]}}) begin
			return d[D2_W-1] ? OUT_MIN : OUT_MAX;
		end
		return d[W-1:0];
	endfunction

	// ---------------- configuration registers ----------------
	logic [MU_W-1:0]   mu_q;
	logic [COH_W-1:0]  coh_q;
	logic [DEN_W-1:0]  den_q;
	logic [2*MU_W-1:0] mu_sq;

	assign mu_sq = mu_q * mu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q  <= '0;
			coh_q <= '0;
			den_q <= DEN_ONE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_FRICTION: mu_q  <= cfg_wdata[MU_W-1:0];
					REG_COHESION: coh_q <= cfg_wdata[COH_W-1:0];
				endcase
			end
			// 1 + mu^2 follows the friction register
			den_q <= DEN_ONE + DEN_W'(mu_sq >> F);
		end
	end

	// Whole pipeline moves unless the output word is stuck
	logic adv;
	assign adv          = !out_vec.valid || out_vec.ready;
	assign in_vec.ready = adv;

	// ---------------- s1: capture, cohesion shift ----------------
	logic                   v_s1;
	logic signed [W-1:0]    t1_s1, t2_s1, n_s1;
	logic signed [SN_W-1:0] sn_s1;
	logic signed [SN_W-1:0] n_ext, c_ext;

	assign n_ext = SN_W'(in_vec.s_normal);
	assign c_ext = SN_W'(coh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s1 <= in_vec.s_tangent_one;
			t2_s1 <= in_vec.s_tangent_two;
			n_s1  <= in_vec.s_normal;
			sn_s1 <= n_ext + c_ext;
		end
	end

	// ---------------- s2: squares ----------------
	logic                   v_s2;
	logic [W-1:0]           a1_c, a2_c;
	logic [2*W-1:0]         sq1_s2, sq2_s2;
	logic signed [W-1:0]    t1_s2, t2_s2, n_s2;
	logic signed [SN_W-1:0] sn_s2;

	assign a1_c = (t1_s1 < 0) ? W'(-t1_s1) : W'(t1_s1);
	assign a2_c = (t2_s1 < 0) ? W'(-t2_s1) : W'(t2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq1_s2 <= a1_c * a1_c;
			sq2_s2 <= a2_c * a2_c;
			t1_s2  <= t1_s1;
			t2_s2  <= t2_s1;
			n_s2   <= n_s1;
			sn_s2  <= sn_s1;
		end
	end

	// ---------------- s3: sum of squares ----------------
	logic                   v_s3;
	logic [2*W-1:0]         x_s3;
	logic signed [W-1:0]    t1_s3, t2_s3, n_s3;
	logic signed [SN_W-1:0] sn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3  <= sq1_s2 + sq2_s2;
			t1_s3 <= t1_s2;
			t2_s3 <= t2_s2;
			n_s3  <= n_s2;
			sn_s3 <= sn_s2;
		end
	end

	// ---------------- tangential length ----------------
	logic            sq_v;
	logic [W-1:0]    sq_root;
	logic [SB_W-1:0] sq_sb;
	logic [W-1:0]    sq_t1, sq_t2, sq_n;
	logic [SN_W-1:0] sq_sn;

	fcp_isqrt_pipe #(
		.IN_W (2 * W),
		.SB_W (SB_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.in_x      (x_s3),
		.in_sb     ({t1_s3, t2_s3, n_s3, sn_s3}),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_sb    (sq_sb)
	);

	assign {sq_t1, sq_t2, sq_n, sq_sn} = sq_sb;

	// ---------------- sa: mu products ----------------
	logic                   v_sa;
	logic [P1_W-1:0]        p1_sa;
	logic signed [P2_W-1:0] p2_sa;
	logic [W-1:0]           slen_sa;
	logic signed [W-1:0]    t1_sa, t2_sa, n_sa;
	logic signed [SN_W-1:0] sn_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else if (adv) begin
			v_sa <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_sa   <= mu_q * sq_root;
			p2_sa   <= $signed({1'b0, mu_q}) * $signed(sq_sn);
			slen_sa <= sq_root;
			t1_sa   <= sq_t1;
			t2_sa   <= sq_t2;
			n_sa    <= sq_n;
			sn_sa   <= sq_sn;
		end
	end

	// ---------------- sb: cone numerators ----------------
	logic                    v_sb;
	logic signed [NUM_W-1:0] num1_sb, num2_sb;
	logic [W-1:0]            a1_sb, a2_sb;
	side_t                   side_sb;
	logic signed [NUM_W-1:0] sn_w, sl_w, p1_w, p2_w;

	assign sn_w = NUM_W'(sn_sa);
	assign sl_w = NUM_W'(slen_sa);
	assign p1_w = NUM_W'(p1_sa);
	assign p2_w = NUM_W'(p2_sa);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sb <= 1'b0;
		end else if (adv) begin
			v_sb <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_sb      <= -(sn_w <<< F) - p1_w;
			num2_sb      <= (sl_w <<< F) - p2_w;
			a1_sb        <= (t1_sa < 0) ? W'(-t1_sa) : W'(t1_sa);
			a2_sb        <= (t2_sa < 0) ? W'(-t2_sa) : W'(t2_sa);
			side_sb.t1   <= t1_sa;
			side_sb.t2   <= t2_sa;
			side_sb.n    <= n_sa;
			side_sb.slen <= slen_sa;
			side_sb.zero <= (slen_sa == '0);
			side_sb.neg1 <= t1_sa[W-1];
			side_sb.neg2 <= t2_sa[W-1];
		end
	end

	// ---------------- divider array ----------------
	// g1, g2 run one quotient bit per stage; ux, uy finish in the first F+1 stages
	logic [NU_W-1:0] nu1, nu2;
	gdiv_t           g1_init, g2_init;

	assign nu1 = (num1_sb > 0) ? NU_W'(num1_sb) : '0;
	assign nu2 = (num2_sb > 0) ? NU_W'(num2_sb) : '0;
	assign g1_init = '{rem: DEN_W'(nu1[NU_W-1:QG_W]), dvd: nu1[QG_W-1:0], quo: '0};
	assign g2_init = '{rem: DEN_W'(nu2[NU_W-1:QG_W]), dvd: nu2[QG_W-1:0], quo: '0};

	logic  dv_q [QG_W];
	gdiv_t g1_d [QG_W];
	gdiv_t g2_d [QG_W];
	udiv_t u1_d [QG_W];
	udiv_t u2_d [QG_W];
	side_t sd_d [QG_W];

	for (genvar k = 0; k < QG_W; k++) begin : g_div
		logic  v_in;
		gdiv_t g1_in, g2_in;
		udiv_t u1_in, u2_in;
		side_t sd_in;

		if (k == 0) begin : g_first
			assign v_in  = v_sb;
			assign g1_in = g1_init;
			assign g2_in = g2_init;
			assign u1_in = '{rem: a1_sb, quo: '0};
			assign u2_in = '{rem: a2_sb, quo: '0};
			assign sd_in = side_sb;
		end else begin : g_next
			assign v_in  = dv_q[k-1];
			assign g1_in = g1_d[k-1];
			assign g2_in = g2_d[k-1];
			assign u1_in = u1_d[k-1];
			assign u2_in = u2_d[k-1];
			assign sd_in = sd_d[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[k] <= 1'b0;
			end else if (adv) begin
				dv_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				g1_d[k] <= gdiv_step(g1_in, den_q);
				g2_d[k] <= gdiv_step(g2_in, den_q);
				sd_d[k] <= sd_in;
			end
		end

		if (k <= F) begin : g_ustep
			always_ff @(posedge clk) begin
				if (adv) begin
					u1_d[k] <= udiv_step(u1_in, sd_in.slen, (k == 0));
					u2_d[k] <= udiv_step(u2_in, sd_in.slen, (k == 0));
				end
			end
		end else begin : g_uhold
			always_ff @(posedge clk) begin
				if (adv) begin
					u1_d[k] <= u1_in;
					u2_d[k] <= u2_in;
				end
			end
		end
	end

	// ---------------- sc: unit direction, mu*g ----------------
	side_t                   sd_l;
	logic signed [UX_W-1:0]  q1e, q2e, ux_c, uy_c;

	assign sd_l = sd_d[LAST];
	assign q1e  = $signed({1'b0, u1_d[LAST].quo});
	assign q2e  = $signed({1'b0, u2_d[LAST].quo});
	assign ux_c = sd_l.zero ? UX_ONE : (sd_l.neg1 ? -q1e : q1e);
	assign uy_c = sd_l.zero ? '0 : (sd_l.neg2 ? -q2e : q2e);

	logic                   v_sc;
	logic [QG_W-1:0]        g1_sc, g2_sc;
	logic [PM_W-1:0]        pm1_sc, pm2_sc;
	logic signed [UX_W-1:0] ux_sc, uy_sc;
	logic signed [W-1:0]    t1_sc, t2_sc, n_sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else if (adv) begin
			v_sc <= dv_q[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g1_sc  <= g1_d[LAST].quo;
			g2_sc  <= g2_d[LAST].quo;
			pm1_sc <= mu_q * g1_d[LAST].quo;
			pm2_sc <= mu_q * g2_d[LAST].quo;
			ux_sc  <= ux_c;
			uy_sc  <= uy_c;
			t1_sc  <= sd_l.t1;
			t2_sc  <= sd_l.t2;
			n_sc   <= sd_l.n;
		end
	end

	// ---------------- sd: h and normal projection ----------------
	logic                   v_sd;
	logic signed [H_W-1:0]  h_sd;
	logic signed [M2_W-1:0] m2_sd;
	logic signed [UX_W-1:0] ux_sd, uy_sd;
	logic signed [W-1:0]    t1_sd, t2_sd, n_sd;
	logic signed [H_W-1:0]  g2_h, pm1_h;
	logic signed [M2_W-1:0] g1_m, pm2_m;

	assign g2_h  = H_W'(g2_sc);
	assign pm1_h = H_W'(pm1_sc >> F);
	assign g1_m  = M2_W'(g1_sc);
	assign pm2_m = M2_W'(pm2_sc >> F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (adv) begin
			v_sd <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_sd  <= g2_h - pm1_h;
			m2_sd <= -(g1_m + pm2_m);
			ux_sd <= ux_sc;
			uy_sd <= uy_sc;
			t1_sd <= t1_sc;
			t2_sd <= t2_sc;
			n_sd  <= n_sc;
		end
	end

	// ---------------- se: tangential projection ----------------
	logic                   v_se;
	logic signed [HX_W-1:0] hx_se, hy_se;
	logic signed [M2_W-1:0] m2_se;
	logic signed [W-1:0]    t1_se, t2_se, n_se;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_se <= 1'b0;
		end else if (adv) begin
			v_se <= v_sd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_se <= h_sd * ux_sd;
			hy_se <= h_sd * uy_sd;
			m2_se <= m2_sd;
			t1_se <= t1_sd;
			t2_se <= t2_sd;
			n_se  <= n_sd;
		end
	end

	// ---------------- output register: subtract and saturate ----------------
	logic signed [D0_W-1:0] d0_c, d1_c;
	logic signed [D2_W-1:0] d2_c;

	assign d0_c = D0_W'(t1_se) - D0_W'($signed(hx_se[HX_W-1:F]));
	assign d1_c = D0_W'(t2_se) - D0_W'($signed(hy_se[HX_W-1:F]));
	assign d2_c = D2_W'(n_se) - D2_W'(m2_se);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vec.valid <= 1'b0;
		end else if (adv) begin
			out_vec.valid <= v_se;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_vec.r_tangent_one <= sat0(d0_c);
			out_vec.r_tangent_two <= sat0(d1_c);
			out_vec.r_normal      <= sat2(d2_c);
		end
	end

	// ---------------- assertions ----------------
	// Cone denominator never drops below one
	a_den_min: assert property (@(posedge clk) disable iff (!arst_n)
		den_q[DEN_W-1:F] != '0)
		else $error("cone denominator below one");

	// Zero length only for a zero tangential part
	a_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_v && sq_root == '0) |-> (sq_t1 == '0 && sq_t2 == '0))
		else $error("zero tangential length with nonzero tangent");

	// Unit direction magnitude never exceeds one
	a_u_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_q[LAST] && !sd_l.zero) |->
		(u1_d[LAST].quo <= Q_ONE && u2_d[LAST].quo <= Q_ONE))
		else $error("unit direction out of range");

	// Divider remainders stay below the denominator
	a_g_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_q[LAST] |-> (g1_d[LAST].rem < den_q && g2_d[LAST].rem < den_q))
		else $error("cone divider remainder out of range");

endmodule

// ===== dv/friction_cone_projection_unit_test.sv =====
// Testbench for friction_cone_projection_unit: drives contact vectors, predicts projected words.
// Depends on fcp_pkg, fcp_stream_if and the unit's RTL.
`timescale 1ns / 100ps

module friction_cone_projection_unit_test;
	import fcp_pkg::*;

	localparam int DW    = 32;
	localparam int FRAC  = 16;
	localparam int LAT   = 77;
	localparam longint ONE = 64'sd1 <<< FRAC;

	typedef logic signed [DW-1:0] q_t;
	typedef struct {
		q_t t1;
		q_t t2;
		q_t n;
	} contact_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fcp_in_if #(.DATA_WIDTH(DW)) in_vec ();
	fcp_out_if #(.DATA_WIDTH(DW)) out_vec ();

	friction_cone_projection_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_vec    (in_vec),
		.out_vec   (out_vec)
	);

	// local copy of the registers
	logic [MU_W-1:0]  mu_reg;
	logic [COH_W-1:0] coh_reg;

	contact_t pending_vecs[$];
	contact_t projected_q[$];
	int  fails;
	int  cyc;
	bit  in_taken;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic q_t clip(longint v);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (DW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return q_t'(v);
	endfunction

	// cone projection of one contact vector, all in 64-bit, signed but for the tangent magnitudes
	function automatic contact_t project_on_cone(contact_t s);
		longint t1, t2, n, mu, sn, slen, den, num1, num2, g1, g2;
		longint ux, uy, h, m0, m1, m2;
		longint unsigned a1, a2;
		contact_t r;
		t1 = s.t1;
		t2 = s.t2;
		n = s.n;
		mu = longint'(mu_reg);
		a1 = (t1 < 0) ? -t1 : t1;
		a2 = (t2 < 0) ? -t2 : t2;
		sn = n + longint'(coh_reg);
		slen = longint'(int_sqrt(a1 * a1 + a2 * a2));
		den = ONE + ((mu * mu) >>> FRAC);
		num1 = -(sn * ONE) - mu * slen;
		num2 = slen * ONE - mu * sn;
		g1 = (num1 > 0) ? num1 / den : 0;
		g2 = (num2 > 0) ? num2 / den : 0;
		// zero tangential length: direction (1,0)
		if (slen != 0) begin
			ux = (t1 * ONE) / slen;
			uy = (t2 * ONE) / slen;
		end else begin
			ux = ONE;
			uy = 0;
		end
		h = g2 - ((mu * g1) >>> FRAC);
		m0 = (h * ux) >>> FRAC;
		m1 = (h * uy) >>> FRAC;
		m2 = -(g1 + ((mu * g2) >>> FRAC));
		r.t1 = clip(t1 - m0);
		r.t2 = clip(t2 - m1);
		r.n  = clip(n - m2);
		return r;
	endfunction

	function automatic q_t rand_comp();
		case ($urandom_range(0, 5))
			0: return q_t'($urandom());
			1: return q_t'($urandom_range(0, 1 << 20)) - q_t'(1 << 19);
			2: return q_t'($urandom_range(0, 1 << 26)) - q_t'(1 << 25);
			3: return $urandom_range(0, 1) ? q_t'(32'h7fffffff) : q_t'(32'h80000000);
			4: return '0;
			default: return q_t'($urandom_range(0, 1 << 24)) - q_t'(1 << 23);
		endcase
	endfunction

	function automatic contact_t mk(q_t a, q_t b, q_t c);
		contact_t v;
		v.t1 = a;
		v.t2 = b;
		v.n = c;
		return v;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRICTION)
			mu_reg = val[MU_W-1:0];
		else
			coh_reg = val[COH_W-1:0];
	endtask

	// wait until no word is queued, offered or in flight
	task automatic drain();
		while (pending_vecs.size() != 0 || in_vec.valid || projected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// quiet window in each period of the cycle counter where neither side idles
	function automatic bit take_break();
		if ((cyc % 4000) < 900)
			return 1'b0;
		return $urandom_range(0, 99) < 30;
	endfunction

	// input driver, changes on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_vec.valid || in_taken) begin
				if (pending_vecs.size() != 0 && !take_break()) begin
					contact_t v;
					v = pending_vecs.pop_front();
					in_vec.valid <= 1'b1;
					in_vec.s_tangent_one <= v.t1;
					in_vec.s_tangent_two <= v.t2;
					in_vec.s_normal <= v.n;
				end else begin
					in_vec.valid <= 1'b0;
				end
			end
			out_vec.ready <= !take_break();
		end
	end

	// monitor: predict accepted words, check returned words
	always @(posedge clk) begin
		cyc <= cyc + 1;
		in_taken <= in_vec.valid && in_vec.ready;
		if (in_vec.valid && in_vec.ready)
			projected_q.push_back(project_on_cone(mk(in_vec.s_tangent_one,
				in_vec.s_tangent_two, in_vec.s_normal)));
		if (out_vec.valid && out_vec.ready) begin
			if (projected_q.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				contact_t e;
				e = projected_q.pop_front();
				if (out_vec.r_tangent_one !== e.t1) begin
					$error("r_tangent_one exp %0d got %0d", e.t1, out_vec.r_tangent_one);
					fails++;
				end
				if (out_vec.r_tangent_two !== e.t2) begin
					$error("r_tangent_two exp %0d got %0d", e.t2, out_vec.r_tangent_two);
					fails++;
				end
				if (out_vec.r_normal !== e.n) begin
					$error("r_normal exp %0d got %0d", e.n, out_vec.r_normal);
					fails++;
				end
			end
		end
	end

	initial begin
		q_t mx;
		q_t mn;
		fails = 0;
		cyc = 0;
		in_taken = 1'b0;
		mu_reg = '0;
		coh_reg = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_FRICTION;
		cfg_wdata = '0;
		in_vec.valid = 1'b0;
		in_vec.s_tangent_one = '0;
		in_vec.s_tangent_two = '0;
		in_vec.s_normal = '0;
		out_vec.ready = 1'b0;
		mx = q_t'(32'h7fffffff);
		mn = q_t'(32'h80000000);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: mu = 0.5, small cohesion
		write_reg(REG_FRICTION, 31'h8000);
		write_reg(REG_COHESION, 31'h4000);
		pending_vecs.push_back(mk(0, 0, 0));
		pending_vecs.push_back(mk(0, 0, 32'sh10000));
		pending_vecs.push_back(mk(0, 0, -32'sh30000));
		pending_vecs.push_back(mk(32'sh10000, 0, 32'sh10000));
		pending_vecs.push_back(mk(-32'sh20000, 32'sh10000, 32'sh8000));
		pending_vecs.push_back(mk(32'sh30000, -32'sh40000, -32'sh10000));
		pending_vecs.push_back(mk(1, -1, 0));
		pending_vecs.push_back(mk(mx, mx, mx));
		pending_vecs.push_back(mk(mn, mn, mn));
		pending_vecs.push_back(mk(mx, mn, mn));
		pending_vecs.push_back(mk(mn, mx, mx));
		pending_vecs.push_back(mk(0, mx, 0));
		pending_vecs.push_back(mk(mn, 0, 0));
		pending_vecs.push_back(mk(0, 0, mn));
		pending_vecs.push_back(mk(0, 0, mx));
		pending_vecs.push_back(mk(32'sh100, 32'sh100, -32'sh7fff0000));
		pending_vecs.push_back(mk(32'sh10000, 32'sh10000, 32'sh7fff0000));
		pending_vecs.push_back(mk(-1, 0, -1));
		drain();

		// random phases over several register settings, extremes first
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_FRICTION, 31'd0);
					write_reg(REG_COHESION, 31'd0);
				end
				1: begin
					write_reg(REG_FRICTION, 31'h3ffff);
					write_reg(REG_COHESION, 31'h7fffffff);
				end
				2: begin
					write_reg(REG_FRICTION, 31'h10000);
					write_reg(REG_COHESION, 31'd0);
				end
				3: begin
					write_reg(REG_FRICTION, 31'h3ffff);
					write_reg(REG_COHESION, 31'd0);
				end
				default: begin
					write_reg(REG_FRICTION, 31'($urandom_range(0, 32'h3ffff)));
					write_reg(REG_COHESION, $urandom_range(0, 1) ?
						31'($urandom_range(0, 32'h7ffff)) : 31'($urandom()));
				end
			endcase
			for (int k = 0; k < 162; k++)
				pending_vecs.push_back(mk(rand_comp(), rand_comp(), rand_comp()));
			drain();
		end

		repeat (LAT + 20) @(posedge clk);
		if (fails == 0 && projected_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/fcp_pkg.sv
hw/rtl/fcp_stream_if.sv
hw/rtl/fcp_isqrt_pipe.sv
hw/rtl/friction_cone_projection_unit.sv
dv/friction_cone_projection_unit_test.sv
